// ===== design/icf_pkg.sv =====
// Shared types and constants of the 3x3 correlation filter.
package icf_pkg;

  localparam int KERNEL_SIZE = 3;
  localparam int MAX_HEIGHT  = 1024;
  localparam int PIX_W       = 8;
  localparam int POS_W       = 10;
  localparam int GEOM_W      = 11;
  localparam int COEF_W      = 16;
  localparam int COEF_ROW_W  = 48;
  localparam int ANCHOR_W    = 2;
  localparam int DELTA_W     = 9;

  localparam int DATA_W = 64;
  localparam int ADDR_W = 6;

  // signed coefficient times unsigned pixel, then sums of three and of nine plus offset
  localparam int PROD_W   = 24;
  localparam int ROWSUM_W = 26;
  localparam int ACC_W    = 29;

  localparam logic signed [ACC_W-1:0] CLAMP_HI = ACC_W'(255 * 256);
  localparam logic [ANCHOR_W-1:0]     ANCHOR_MAX = ANCHOR_W'(2);
  localparam logic [GEOM_W-1:0]       GEOM_MIN   = GEOM_W'(3);
  localparam logic [GEOM_W-1:0]       HEIGHT_MAX = GEOM_W'(MAX_HEIGHT);

  typedef enum logic [2:0] {
    REG_COEF_ROW0    = 3'd0,
    REG_COEF_ROW1    = 3'd1,
    REG_COEF_ROW2    = 3'd2,
    REG_ANCHOR_COL   = 3'd3,
    REG_ANCHOR_ROW   = 3'd4,
    REG_OFFSET_DELTA = 3'd5,
    REG_FRAME_WIDTH  = 3'd6,
    REG_FRAME_HEIGHT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
  } pixel_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             frame_last;
  } result_item_t;

  function automatic logic signed [PROD_W-1:0] coef_mul(input logic [COEF_W-1:0] coef,
                                                        input logic [PIX_W-1:0] pix);
    logic signed [PROD_W:0] full;
    full = $signed(coef) * $signed({1'b0, pix});
    return $signed(full[PROD_W-1:0]);
  endfunction

endpackage

// ===== design/icf_stream_if.sv =====
// Valid/ready stream channel carrying one item of a given payload type.
interface icf_stream_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/image_correlation_filter_3x3.sv =====
// Top level of the streaming 3x3 correlation filter, one channel.
//
// pixels (sink) takes one 8-bit pixel per item in raster order; results (source) gives
// one item per pixel that completes a full in-bounds 3x3 window: the clamped value,
// its destination row and column (window top/left plus anchor) and a last-of-frame flag.
// Kernel, anchor, offset and frame geometry sit in an APB register file (64-bit data,
// register i at byte address 8*i); write it only while the pipeline is empty.
// Throughput is one item per cycle while results is not stalled. The line store is one
// MAX_WIDTH x 16-bit RAM holding the two rows above; it is read when an item is accepted,
// written back when the item moves on from the first stage, and the same column only comes
// round again after a full row. A pixel passes six registers to its result (RAM read,
// window, products, row sums, offset, clamp).
// When results is stalled, pixels keep being taken until the six stages are full;
// ready then follows the output handshake.
// Reset clears the row and column counters, the pipeline valids and loads the default
// registers (kernel only 256 at row 1, col 0; anchor 1,1; 640x480). The line store is not cleared.
module image_correlation_filter_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  icf_stream_if.sink                  pixels,
  icf_stream_if.source                results,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [icf_pkg::ADDR_W-1:0]  paddr,
  input  logic [icf_pkg::DATA_W-1:0]  pwdata,
  output logic [icf_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import icf_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = (CW + 1 > GEOM_W) ? CW + 1 : GEOM_W;
  localparam int OCW = (CW > POS_W) ? CW : POS_W;

  // configuration registers
  logic [COEF_ROW_W-1:0]    coef_row [KERNEL_SIZE];
  logic [ANCHOR_W-1:0]      anchor_col;
  logic [ANCHOR_W-1:0]      anchor_row;
  logic signed [DELTA_W-1:0] offset_delta;
  logic [GEOM_W-1:0]        frame_width;
  logic [GEOM_W-1:0]        frame_height;

  reg_idx_t reg_idx;
  assign reg_idx = reg_idx_t'(paddr[5:3]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_row[0]  <= '0;
      coef_row[1]  <= COEF_ROW_W'(256);
      coef_row[2]  <= '0;
      anchor_col   <= ANCHOR_W'(1);
      anchor_row   <= ANCHOR_W'(1);
      offset_delta <= '0;
      frame_width  <= GEOM_W'(640);
      frame_height <= GEOM_W'(480);
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_COEF_ROW0:    coef_row[0]  <= pwdata[COEF_ROW_W-1:0];
        REG_COEF_ROW1:    coef_row[1]  <= pwdata[COEF_ROW_W-1:0];
        REG_COEF_ROW2:    coef_row[2]  <= pwdata[COEF_ROW_W-1:0];
        REG_ANCHOR_COL:   anchor_col   <= pwdata[ANCHOR_W-1:0];
        REG_ANCHOR_ROW:   anchor_row   <= pwdata[ANCHOR_W-1:0];
        REG_OFFSET_DELTA: offset_delta <= $signed(pwdata[DELTA_W-1:0]);
        REG_FRAME_WIDTH:  frame_width  <= pwdata[GEOM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[GEOM_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_COEF_ROW0:    prdata = DATA_W'(coef_row[0]);
      REG_COEF_ROW1:    prdata = DATA_W'(coef_row[1]);
      REG_COEF_ROW2:    prdata = DATA_W'(coef_row[2]);
      REG_ANCHOR_COL:   prdata = DATA_W'(anchor_col);
      REG_ANCHOR_ROW:   prdata = DATA_W'(anchor_row);
      REG_OFFSET_DELTA: prdata = DATA_W'({offset_delta});
      REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height);
    endcase
  end

  // effective geometry and anchor
  logic [WW-1:0]       w_eff;
  logic [GEOM_W-1:0]   h_eff;
  logic [ANCHOR_W-1:0] ac_eff;
  logic [ANCHOR_W-1:0] ar_eff;

  always_comb begin
    if (frame_width < GEOM_MIN)                 w_eff = WW'(GEOM_MIN);
    else if (WW'(frame_width) > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else                                        w_eff = WW'(frame_width);
    if (frame_height < GEOM_MIN)        h_eff = GEOM_MIN;
    else if (frame_height > HEIGHT_MAX) h_eff = HEIGHT_MAX;
    else                                h_eff = frame_height;
    ac_eff = (anchor_col > ANCHOR_MAX) ? ANCHOR_MAX : anchor_col;
    ar_eff = (anchor_row > ANCHOR_MAX) ? ANCHOR_MAX : anchor_row;
  end

  // pipeline control
  logic s1_v, s2_v, s3_v, s4_v, s5_v, out_v;
  logic s1_free, s2_free, s3_free, s4_free, s5_free, out_free;
  logic accept;

  always_comb begin
    out_free = !out_v || results.ready;
    s5_free  = !s5_v || out_free;
    s4_free  = !s4_v || s5_free;
    s3_free  = !s3_v || s4_free;
    s2_free  = !s2_v || s3_free;
    s1_free  = !s1_v || s2_free;
  end

  assign pixels.ready = s1_free;
  assign accept       = pixels.valid && s1_free;

  // position of the incoming pixel
  logic [CW-1:0]     col_count, col_count_next;
  logic [POS_W-1:0]  row_count, row_count_next;
  logic [CW-1:0]     cur_col;
  logic [POS_W-1:0]  cur_row;
  logic [GEOM_W-1:0] row_a, row_b;
  logic [WW-1:0]     col_inc;
  logic [OCW-1:0]    dst_col;
  logic [POS_W-1:0]  dst_row;
  logic              cur_res, cur_last;

  always_comb begin
    if (WW'(col_count) >= w_eff) begin
      cur_col = '0;
      row_a   = GEOM_W'(row_count) + GEOM_W'(1);
    end else begin
      cur_col = col_count;
      row_a   = GEOM_W'(row_count);
    end
    cur_row  = (row_a >= h_eff) ? '0 : row_a[POS_W-1:0];
    cur_res  = (cur_row >= POS_W'(2)) && (cur_col >= CW'(2));
    cur_last = (GEOM_W'(cur_row) == h_eff - GEOM_W'(1)) && (WW'(cur_col) == w_eff - WW'(1));
    dst_row  = cur_row + POS_W'(ar_eff) - POS_W'(2);
    dst_col  = OCW'(cur_col) + OCW'(ac_eff) - OCW'(2);

    col_inc = WW'(cur_col) + WW'(1);
    if (col_inc >= w_eff) begin
      col_count_next = '0;
      row_b          = GEOM_W'(cur_row) + GEOM_W'(1);
      row_count_next = (row_b >= h_eff) ? '0 : row_b[POS_W-1:0];
    end else begin
      col_count_next = col_inc[CW-1:0];
      row_b          = GEOM_W'(cur_row);
      row_count_next = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // line store: [7:0] row above, [15:8] two rows above
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] mem_rd;

  logic [PIX_W-1:0] s1_px;
  logic [CW-1:0]    s1_col;
  logic             s1_res, s1_last;
  logic [POS_W-1:0] s1_row_o, s1_col_o;
  logic             s1_go;

  assign s1_go = s1_v && s2_free;

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_rd <= line_mem[cur_col];
    end
    if (s1_go) begin
      line_mem[s1_col] <= {mem_rd[PIX_W-1:0], s1_px};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s1_free) begin
      s1_v <= pixels.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px    <= pixels.data.pixel_in;
      s1_col   <= cur_col;
      s1_res   <= cur_res;
      s1_last  <= cur_last;
      s1_row_o <= dst_row;
      s1_col_o <= dst_col[POS_W-1:0];
    end
  end

  // window: row 0 oldest line, column 2 newest pixel
  logic [PIX_W-1:0] win [KERNEL_SIZE][KERNEL_SIZE];
  logic             s2_last;
  logic [POS_W-1:0] s2_row_o, s2_col_o;

  always_ff @(posedge clk) begin
    if (s1_go) begin
      for (int t = 0; t < KERNEL_SIZE; t++) begin
        win[t][0] <= win[t][1];
        win[t][1] <= win[t][2];
      end
      win[0][2] <= mem_rd[2*PIX_W-1:PIX_W];
      win[1][2] <= mem_rd[PIX_W-1:0];
      win[2][2] <= s1_px;
      s2_last   <= s1_last;
      s2_row_o  <= s1_row_o;
      s2_col_o  <= s1_col_o;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s2_free) begin
      s2_v <= s1_v && s1_res;
    end
  end

  // products
  logic signed [PROD_W-1:0] s3_prod [KERNEL_SIZE][KERNEL_SIZE];
  logic                     s3_last;
  logic [POS_W-1:0]         s3_row_o, s3_col_o;

  always_ff @(posedge clk) begin
    if (s2_v && s3_free) begin
      for (int t = 0; t < KERNEL_SIZE; t++) begin
        for (int s = 0; s < KERNEL_SIZE; s++) begin
          s3_prod[t][s] <= coef_mul(coef_row[t][COEF_W*s +: COEF_W], win[t][s]);
        end
      end
      s3_last  <= s2_last;
      s3_row_o <= s2_row_o;
      s3_col_o <= s2_col_o;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (s3_free) begin
      s3_v <= s2_v;
    end
  end

  // row sums
  logic signed [ROWSUM_W-1:0] s4_row [KERNEL_SIZE];
  logic                       s4_last;
  logic [POS_W-1:0]           s4_row_o, s4_col_o;

  always_ff @(posedge clk) begin
    if (s3_v && s4_free) begin
      for (int t = 0; t < KERNEL_SIZE; t++) begin
        s4_row[t] <= ROWSUM_W'(s3_prod[t][0]) + ROWSUM_W'(s3_prod[t][1])
                   + ROWSUM_W'(s3_prod[t][2]);
      end
      s4_last  <= s3_last;
      s4_row_o <= s3_row_o;
      s4_col_o <= s3_col_o;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (s4_free) begin
      s4_v <= s3_v;
    end
  end

  // total plus offset in Q.8
  logic signed [ACC_W-1:0] delta_term;
  logic signed [ACC_W-1:0] s5_acc;
  logic                    s5_last;
  logic [POS_W-1:0]        s5_row_o, s5_col_o;

  assign delta_term = {{(ACC_W-DELTA_W-8){offset_delta[DELTA_W-1]}}, offset_delta, 8'h00};

  always_ff @(posedge clk) begin
    if (s4_v && s5_free) begin
      s5_acc   <= ACC_W'(s4_row[0]) + ACC_W'(s4_row[1]) + ACC_W'(s4_row[2]) + delta_term;
      s5_last  <= s4_last;
      s5_row_o <= s4_row_o;
      s5_col_o <= s4_col_o;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (s5_free) begin
      s5_v <= s4_v;
    end
  end

  // clamp and output register
  result_item_t out_item;
  logic [PIX_W-1:0] clamped;

  always_comb begin
    if (s5_acc[ACC_W-1])       clamped = '0;
    else if (s5_acc > CLAMP_HI) clamped = '1;
    else                        clamped = s5_acc[PIX_W+7:8];
  end

  always_ff @(posedge clk) begin
    if (s5_v && out_free) begin
      out_item.pixel_out  <= clamped;
      out_item.out_row    <= s5_row_o;
      out_item.out_col    <= s5_col_o;
      out_item.frame_last <= s5_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_free) begin
      out_v <= s5_v;
    end
  end

  assign results.valid = out_v;
  assign results.data  = out_item;

endmodule
